// ===== rtl/core/lmm_pkg.sv =====
// Package for the linked multimap table: sizes, link coding, command and
// status codes, sequencer state type.
// No dependencies.
package lmm_pkg;

   localparam int CAPACITY = 32;                     // number of slots
   localparam int IDX_W    = $clog2(CAPACITY);       // slot address width
   localparam int LINK_W   = $clog2(CAPACITY + 1);   // link width, holds null
   localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(CAPACITY);

   localparam int KEY_W   = 16;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 6;

   // request and response word layouts
   localparam int REQ_DATA_W = KEY_W + VALUE_W;               // 48, whole bytes
   localparam int RSP_DATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - VALUE_W - COUNT_W;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_LIST   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_MISSING = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD_TAKE,
      S_ADD_LINK,
      S_WALK,
      S_REM_LINK,
      S_REM_FREE,
      S_RESP,
      S_FLUSH
   } state_type;

endpackage

// ===== rtl/core/linked_multimap_table.sv =====
// Linked multimap table top level: slot memories, link list walker and
// response register. Depends on lmm_pkg.
//
// Sequencing: an add goes through accept, take free slot, link at tail and
// respond; an add on a full table goes from accept straight to respond.
// Remove, search and list walk the list one slot per cycle through the link
// memory read port, except while a held match waits on an rsp stall; the
// walk visits at most CAPACITY slots. A remove that finds its pair unlinks
// it and frees the slot before it responds.
// One request is in flight at a time; req_tready is high only in idle.
// Reset (synchronous, active high) empties the list, points the free list
// at slot 0 and clears all link valid bits; key/value slots are not cleared.
module linked_multimap_table
   import lmm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request word
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // key[15:0], value[47:16]
   input  logic [1:0]            req_tuser,   // cmd[1:0]
   // response word
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // found_value[31:0], count[37:32], zero pad
   output logic [2:0]            rsp_tuser,   // status[1:0], has_value[2]
   output logic                  rsp_tlast
);

   // ---------------------------------------------------------------------
   // state
   // ---------------------------------------------------------------------
   state_type state_ff, state_in;

   cmd_type            cmd_ff,   cmd_in;
   logic [KEY_W-1:0]   key_ff,   key_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   status_type         status_ff, status_in;

   logic [LINK_W-1:0]  head_ff,  head_in;
   logic [LINK_W-1:0]  tail_ff,  tail_in;
   logic [LINK_W-1:0]  free_ff,  free_in;
   logic [LINK_W-1:0]  count_ff, count_in;

   // walk cursor; cur_ff also holds the new slot during an add
   logic [LINK_W-1:0]  cur_ff,   cur_in;
   logic [LINK_W-1:0]  prev_ff,  prev_in;
   logic [LINK_W-1:0]  nxt_ff,   nxt_in;
   logic [LINK_W-1:0]  steps_ff, steps_in;

   // one match held back so the final one can carry tlast
   logic               pend_vld_ff, pend_vld_in;
   logic [VALUE_W-1:0] pend_val_ff, pend_val_in;

   // response register
   logic               rsp_vld_ff, rsp_vld_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_has_ff,  rsp_has_in;
   logic [VALUE_W-1:0] rsp_val_ff,  rsp_val_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // ---------------------------------------------------------------------
   // slot memories: key/value written once per add, links with valid bits
   // so an unwritten link reads as its reset value i+1
   // ---------------------------------------------------------------------
   logic [KEY_W-1:0]   key_mem  [CAPACITY];
   logic [VALUE_W-1:0] val_mem  [CAPACITY];
   logic [LINK_W-1:0]  link_mem [CAPACITY];
   logic [CAPACITY-1:0] link_vld_ff;

   logic [IDX_W-1:0]   rd_addr;
   logic [KEY_W-1:0]   rd_key_ff;
   logic [VALUE_W-1:0] rd_val_ff;
   logic [LINK_W-1:0]  rd_link_ff;

   logic               kv_we;
   logic               link_we;
   logic [IDX_W-1:0]   link_waddr;
   logic [LINK_W-1:0]  link_wdata;

   always_ff @(posedge clock) begin
      if (kv_we) begin
         key_mem[free_ff[IDX_W-1:0]] <= key_ff;
         val_mem[free_ff[IDX_W-1:0]] <= value_ff;
      end
      rd_key_ff <= key_mem[rd_addr];
      rd_val_ff <= val_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (link_vld_ff[rd_addr]) begin
         rd_link_ff <= link_mem[rd_addr];
      end else begin
         rd_link_ff <= LINK_W'(rd_addr) + LINK_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_vld_ff <= '0;
      end else if (link_we) begin
         link_vld_ff[link_waddr] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // handshake helpers
   // ---------------------------------------------------------------------
   logic req_fire;
   logic out_free;
   logic walk_end;
   logic hit;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_vld_ff || rsp_tready;

   // walk stops at null/out-of-range link or after CAPACITY slots
   assign walk_end = (steps_ff == NIL_LINK) || (cur_ff >= NIL_LINK);
   assign hit      = (cmd_ff == CMD_LIST) ||
                     ((rd_key_ff == key_ff) &&
                      ((cmd_ff != CMD_REMOVE) || (rd_val_ff == value_ff)));

   // ---------------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (cmd_type'(req_tuser) == CMD_ADD) begin
                  state_in = (free_ff >= NIL_LINK) ? S_RESP : S_ADD_TAKE;
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_ADD_TAKE: state_in = S_ADD_LINK;
         S_ADD_LINK: state_in = S_RESP;
         S_WALK: begin
            if (walk_end) begin
               state_in = (cmd_ff == CMD_REMOVE) ? S_RESP : S_FLUSH;
            end else if (hit && cmd_ff == CMD_REMOVE) begin
               state_in = S_REM_LINK;
            end
         end
         S_REM_LINK: state_in = S_REM_FREE;
         S_REM_FREE: state_in = S_RESP;
         S_RESP, S_FLUSH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // datapath and sequencer outputs
   // ---------------------------------------------------------------------
   logic               push;
   status_type         push_status;
   logic               push_has;
   logic [VALUE_W-1:0] push_val;
   logic               push_last;

   always_comb begin
      cmd_in      = cmd_ff;
      key_in      = key_ff;
      value_in    = value_ff;
      status_in   = status_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      free_in     = free_ff;
      count_in    = count_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      nxt_in      = nxt_ff;
      steps_in    = steps_ff;
      pend_vld_in = pend_vld_ff;
      pend_val_in = pend_val_ff;

      rd_addr     = cur_ff[IDX_W-1:0];
      kv_we       = 1'b0;
      link_we     = 1'b0;
      link_waddr  = cur_ff[IDX_W-1:0];
      link_wdata  = free_ff;

      push        = 1'b0;
      push_status = ST_OK;
      push_has    = 1'b0;
      push_val    = '0;
      push_last   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in      = cmd_type'(req_tuser);
               key_in      = req_tdata[KEY_W-1:0];
               value_in    = req_tdata[KEY_W +: VALUE_W];
               status_in   = ST_OK;
               cur_in      = head_ff;
               prev_in     = NIL_LINK;
               steps_in    = '0;
               pend_vld_in = 1'b0;
               if (cmd_type'(req_tuser) == CMD_ADD) begin
                  // fetch link of the first free slot
                  rd_addr = free_ff[IDX_W-1:0];
                  if (free_ff >= NIL_LINK) begin
                     status_in = ST_FULL;
                  end
               end else begin
                  rd_addr = head_ff[IDX_W-1:0];
               end
            end
         end

         S_ADD_TAKE: begin
            kv_we      = 1'b1;
            link_we    = 1'b1;
            link_waddr = free_ff[IDX_W-1:0];
            link_wdata = NIL_LINK;
            cur_in     = free_ff;
            free_in    = rd_link_ff;
         end

         S_ADD_LINK: begin
            if (count_ff == '0 || tail_ff >= NIL_LINK) begin
               head_in = cur_ff;
            end else begin
               link_we    = 1'b1;
               link_waddr = tail_ff[IDX_W-1:0];
               link_wdata = cur_ff;
            end
            tail_in  = cur_ff;
            count_in = count_ff + LINK_W'(1);
         end

         S_WALK: begin
            if (walk_end) begin
               if (cmd_ff == CMD_REMOVE) begin
                  status_in = ST_MISSING;
               end
            end else if (hit && cmd_ff == CMD_REMOVE) begin
               nxt_in = rd_link_ff;
            end else if (!hit || !pend_vld_ff || out_free) begin
               if (hit) begin
                  // release the held match, hold the new one
                  push        = pend_vld_ff;
                  push_has    = 1'b1;
                  push_val    = pend_val_ff;
                  push_last   = 1'b0;
                  pend_vld_in = 1'b1;
                  pend_val_in = rd_val_ff;
               end
               prev_in  = cur_ff;
               cur_in   = rd_link_ff;
               steps_in = steps_ff + LINK_W'(1);
               rd_addr  = rd_link_ff[IDX_W-1:0];
            end
            // otherwise stalled on the response side: re-read current slot
         end

         S_REM_LINK: begin
            if (prev_ff < NIL_LINK) begin
               link_we    = 1'b1;
               link_waddr = prev_ff[IDX_W-1:0];
               link_wdata = nxt_ff;
            end else begin
               head_in = nxt_ff;
            end
            if (nxt_ff >= NIL_LINK) begin
               tail_in = prev_ff;
            end
         end

         S_REM_FREE: begin
            // freed slot goes to the front of the free list
            link_we    = 1'b1;
            link_waddr = cur_ff[IDX_W-1:0];
            link_wdata = free_ff;
            free_in    = cur_ff;
            if (count_ff != '0) begin
               count_in = count_ff - LINK_W'(1);
            end
         end

         S_RESP: begin
            push        = out_free;
            push_status = status_ff;
         end

         S_FLUSH: begin
            push     = out_free;
            push_has = pend_vld_ff;
            push_val = pend_vld_ff ? pend_val_ff : '0;
         end

         default: begin
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_vld_in    = rsp_vld_ff;
      rsp_status_in = rsp_status_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_count_in  = rsp_count_ff;
      if (push) begin
         rsp_vld_in    = 1'b1;
         rsp_status_in = push_status;
         rsp_has_in    = push_has;
         rsp_val_in    = push_val;
         rsp_last_in   = push_last;
         rsp_count_in  = COUNT_W'(count_ff);
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         head_ff     <= NIL_LINK;
         tail_ff     <= NIL_LINK;
         free_ff     <= '0;
         count_ff    <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         free_ff     <= free_in;
         count_ff    <= count_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      nxt_ff        <= nxt_in;
      steps_ff      <= steps_in;
      pend_val_ff   <= pend_val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // ---------------------------------------------------------------------
   // outputs
   // ---------------------------------------------------------------------
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_count_ff, rsp_val_ff};
   assign rsp_tuser  = {rsp_has_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
